// ===== rtl/julian_day_to_jalali_date_defines.svh =====
// Assertion macros for the Julian day to Jalali date converter.
// Used by files that assert; they expect clk and rst_n in scope.
`ifndef JULIAN_DAY_TO_JALALI_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_JALALI_DATE_DEFINES_SVH

// same-cycle implication
`define JDJ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JDJ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jdj_pkg.sv =====
// Shared constants and helper functions for the Julian day to Jalali date converter.
// No dependencies.
package jdj_pkg;

    localparam int DAY_NUMBER_BITS_DEF = 23;
    localparam int YEAR_W              = 16;
    localparam int MONTH_W             = 4;
    localparam int DAY_W               = 5;
    localparam int OUT_TDATA_W         = 32;
    localparam int NSTAGE              = 12;

    // 2820-year cycle split
    localparam int CYCLE_DAYS   = 1029983;
    localparam int CYCLE_W      = 20;
    localparam int REM_W        = 20;
    localparam int CYCLE_BIAS   = 968504;   // three times CYCLE_DAYS minus the year-475 epoch
    localparam int CYCLE_Q_DROP = 18;       // quotient bits = day bits - this
    localparam int EST_SHIFT    = 16;
    localparam int EST_MUL      = 66719;    // floor(2^36 / cycle days)
    localparam int EST_MUL_W    = 17;
    localparam int EST_POST     = 20;

    // year inside the cycle
    localparam int Y366_MUL     = 733431;   // ceil(2^27 / 183)
    localparam int Y366_MUL_W   = 20;
    localparam int Y366_POST    = 27;
    localparam int LONG_YEAR    = 366;
    localparam int A1_W         = 12;
    localparam int A2_W         = 9;
    localparam int NUM_W        = 23;
    localparam int YPOS_MUL_A1  = 2134;
    localparam int YPOS_MUL_A2  = 2816;
    localparam int YPOS_ADD     = 2815;
    localparam int YPOS_DIV     = 1028522;
    localparam int YPOS_MAX_Q   = 6;
    localparam int YCYCLE_W     = 12;
    localparam int CYCLE_YEARS  = 2820;
    localparam int YEAR_BIAS    = 7986;     // 3 * 2820 - 474

    // day of year
    localparam int LEAP_MUL     = 682;
    localparam int LEAP_ADD     = 323158;
    localparam int LEAP_W       = 22;
    localparam int LEAP_SHIFT   = 8;
    localparam int HN_W         = 14;
    localparam int DIV11_MUL    = 11916;    // ceil(2^17 / 11)
    localparam int DIV11_POST   = 17;
    localparam int H_W          = 10;
    localparam int H_BIAS       = 115;
    localparam int DAYS_YEAR    = 365;
    localparam int YDAY_W       = 10;
    localparam int NMONTH       = 12;

    // day of year on which month m + 1 starts
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd1;
            4'd1:    s = 9'd32;
            4'd2:    s = 9'd63;
            4'd3:    s = 9'd94;
            4'd4:    s = 9'd125;
            4'd5:    s = 9'd156;
            4'd6:    s = 9'd187;
            4'd7:    s = 9'd217;
            4'd8:    s = 9'd247;
            4'd9:    s = 9'd277;
            4'd10:   s = 9'd307;
            4'd11:   s = 9'd337;
            default: s = 9'd1;
        endcase
        return s;
    endfunction

    // floor(num / YPOS_DIV), quotient known to stay at or below YPOS_MAX_Q
    function automatic logic [2:0] ypos_quo(input logic [NUM_W-1:0] num);
        logic [YPOS_MAX_Q-1:0] ge;
        for (int k = 1; k <= YPOS_MAX_Q; k++)
        begin
            ge[k-1] = num >= NUM_W'(k * YPOS_DIV);
        end
        return 3'($countones(ge));
    endfunction

endpackage

// ===== rtl/jdj_cycle_div.sv =====
// Pipeline stages 0..3: input register and split of the day number into
// 2820-year cycle index and day inside the cycle. Depends on jdj_pkg.
module jdj_cycle_div
    import jdj_pkg::*;
#(
    parameter int DAY_NUMBER_BITS = DAY_NUMBER_BITS_DEF,
    parameter int QBITS           = DAY_NUMBER_BITS_DEF - CYCLE_Q_DROP
)
(
    input  logic                       clk,
    input  logic [3:0]                 ld,
    input  logic [DAY_NUMBER_BITS-1:0] day_number,
    output logic [QBITS-1:0]           cycle_q,
    output logic [REM_W-1:0]           cycle_rem
);

    localparam int XW  = DAY_NUMBER_BITS + 1;
    localparam int HIW = XW - EST_SHIFT;
    localparam int P1W = HIW + EST_MUL_W;
    localparam int P2W = QBITS + CYCLE_W;
    localparam int RW  = CYCLE_W + 1;

    logic [DAY_NUMBER_BITS-1:0] day_reg;
    logic [XW-1:0]              x_next;
    logic [XW-1:0]              x_reg;
    logic [P1W-1:0]             est_prod;
    logic [QBITS-1:0]           est_q_next;
    logic [QBITS-1:0]           est_q_reg;
    logic [P2W-1:0]             back_prod;
    logic [XW-1:0]              diff;
    logic [RW-1:0]              rem_next;
    logic [RW-1:0]              rem_reg;
    logic [QBITS-1:0]           q2_reg;
    logic [RW-1:0]              rem_sub;
    logic [QBITS-1:0]           q_next;
    logic [QBITS-1:0]           q_reg;
    logic [REM_W-1:0]           r_next;
    logic [REM_W-1:0]           r_reg;

    // biased so the cycle index is never negative; estimate is low by at most one
    assign x_next     = {1'b0, day_reg} + XW'(CYCLE_BIAS);
    assign est_prod   = P1W'(x_next[XW-1:EST_SHIFT]) * P1W'(EST_MUL);
    assign est_q_next = est_prod[EST_POST +: QBITS];

    assign back_prod  = P2W'(est_q_reg) * P2W'(CYCLE_DAYS);
    assign diff       = x_reg - back_prod[XW-1:0];
    assign rem_next   = diff[RW-1:0];

    assign rem_sub    = rem_reg - RW'(CYCLE_DAYS);

    always_comb
    begin
        if (rem_reg >= RW'(CYCLE_DAYS))
        begin
            q_next = q2_reg + QBITS'(1);
            r_next = rem_sub[REM_W-1:0];
        end
        else
        begin
            q_next = q2_reg;
            r_next = rem_reg[REM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            day_reg <= day_number;
        end
        if (ld[1])
        begin
            x_reg     <= x_next;
            est_q_reg <= est_q_next;
        end
        if (ld[2])
        begin
            rem_reg <= rem_next;
            q2_reg  <= est_q_reg;
        end
        if (ld[3])
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign cycle_q   = q_reg;
    assign cycle_rem = r_reg;

endmodule

// ===== rtl/jdj_year_cycle.sv =====
// Pipeline stages 4..7: year inside the 2820-year cycle from the day inside it,
// with the last-day-of-cycle case. Depends on jdj_pkg.
module jdj_year_cycle
    import jdj_pkg::*;
#(
    parameter int QBITS = DAY_NUMBER_BITS_DEF - CYCLE_Q_DROP
)
(
    input  logic                clk,
    input  logic [3:0]          ld,
    input  logic [QBITS-1:0]    cycle_q,
    input  logic [REM_W-1:0]    cycle_rem,
    output logic [QBITS-1:0]    year_q,
    output logic [REM_W-1:0]    year_rem,
    output logic [YCYCLE_W-1:0] ycycle,
    output logic                last_day
);

    localparam int M366W = REM_W - 1 + Y366_MUL_W;

    logic [M366W-1:0]    m366;
    logic [A1_W-1:0]     a1_next;
    logic                sp_next;
    logic [A1_W-1:0]     a1_4_reg;
    logic [REM_W-1:0]    rem4_reg;
    logic [QBITS-1:0]    q4_reg;
    logic                sp4_reg;

    logic [REM_W-1:0]    prod366;
    logic [REM_W-1:0]    a2_full;
    logic [NUM_W-1:0]    t_next;
    logic [A2_W-1:0]     a2_5_reg;
    logic [NUM_W-1:0]    t5_reg;
    logic [A1_W-1:0]     a1_5_reg;
    logic [REM_W-1:0]    rem5_reg;
    logic [QBITS-1:0]    q5_reg;
    logic                sp5_reg;

    logic [NUM_W-1:0]    num_next;
    logic [NUM_W-1:0]    num6_reg;
    logic [A1_W-1:0]     a1_6_reg;
    logic [REM_W-1:0]    rem6_reg;
    logic [QBITS-1:0]    q6_reg;
    logic                sp6_reg;

    logic [YCYCLE_W-1:0] ycyc_next;
    logic [YCYCLE_W-1:0] ycyc7_reg;
    logic [REM_W-1:0]    rem7_reg;
    logic [QBITS-1:0]    q7_reg;
    logic                sp7_reg;

    // rem / 366 as (rem / 2) / 183
    assign m366    = M366W'(cycle_rem[REM_W-1:1]) * M366W'(Y366_MUL);
    assign a1_next = m366[Y366_POST +: A1_W];
    assign sp_next = cycle_rem == REM_W'(CYCLE_DAYS - 1);

    assign prod366 = REM_W'(a1_4_reg) * REM_W'(LONG_YEAR);
    assign a2_full = rem4_reg - prod366;
    assign t_next  = NUM_W'(a1_4_reg) * NUM_W'(YPOS_MUL_A1);

    assign num_next = t5_reg + NUM_W'(a2_5_reg) * NUM_W'(YPOS_MUL_A2) + NUM_W'(YPOS_ADD);

    assign ycyc_next = sp6_reg ? YCYCLE_W'(CYCLE_YEARS)
                               : a1_6_reg + YCYCLE_W'(ypos_quo(num6_reg)) + YCYCLE_W'(1);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            a1_4_reg <= a1_next;
            rem4_reg <= cycle_rem;
            q4_reg   <= cycle_q;
            sp4_reg  <= sp_next;
        end
        if (ld[1])
        begin
            a2_5_reg <= a2_full[A2_W-1:0];
            t5_reg   <= t_next;
            a1_5_reg <= a1_4_reg;
            rem5_reg <= rem4_reg;
            q5_reg   <= q4_reg;
            sp5_reg  <= sp4_reg;
        end
        if (ld[2])
        begin
            num6_reg <= num_next;
            a1_6_reg <= a1_5_reg;
            rem6_reg <= rem5_reg;
            q6_reg   <= q5_reg;
            sp6_reg  <= sp5_reg;
        end
        if (ld[3])
        begin
            ycyc7_reg <= ycyc_next;
            rem7_reg  <= rem6_reg;
            q7_reg    <= q6_reg;
            sp7_reg   <= sp6_reg;
        end
    end

    assign year_q   = q7_reg;
    assign year_rem = rem7_reg;
    assign ycycle   = ycyc7_reg;
    assign last_day = sp7_reg;

endmodule

// ===== rtl/jdj_date_split.sv =====
// Pipeline stages 8..11: absolute year, day of year, then month and day of
// month into the result register. Depends on jdj_pkg.
module jdj_date_split
    import jdj_pkg::*;
#(
    parameter int QBITS = DAY_NUMBER_BITS_DEF - CYCLE_Q_DROP
)
(
    input  logic                clk,
    input  logic [3:0]          ld,
    input  logic [QBITS-1:0]    year_q,
    input  logic [REM_W-1:0]    year_rem,
    input  logic [YCYCLE_W-1:0] ycycle,
    input  logic                last_day,
    output logic [YEAR_W-1:0]   jalali_year,
    output logic [MONTH_W-1:0]  jalali_month,
    output logic [DAY_W-1:0]    jalali_day
);

    localparam int YB  = QBITS + 13;
    localparam int HMW = 2 * HN_W;

    logic [YCYCLE_W-1:0]  k;
    logic [LEAP_W-1:0]    leap_num;
    logic [YB-1:0]        year_next;
    logic [YDAY_W-1:0]    yd0_next;
    logic [HN_W-1:0]      hn8_reg;
    logic [YB-1:0]        year8_reg;
    logic [YDAY_W-1:0]    yd0_8_reg;
    logic                 sp8_reg;

    logic [HMW-1:0]       hmul;
    logic [YB-1:0]        yadj;
    logic [H_W-1:0]       h9_reg;
    logic [YEAR_W-1:0]    year9_reg;
    logic [YDAY_W-1:0]    yd0_9_reg;
    logic                 sp9_reg;

    logic [YDAY_W-1:0]    yday_next;
    logic [YDAY_W-1:0]    yday10_reg;
    logic [YEAR_W-1:0]    year10_reg;

    logic [NMONTH-2:0]    ge;
    logic [MONTH_W-1:0]   mi;
    logic [YDAY_W-1:0]    day_full;
    logic [YEAR_W-1:0]    year_reg;
    logic [MONTH_W-1:0]   month_reg;
    logic [DAY_W-1:0]     day_reg;

    // year position modulo 2820; the last day of a cycle counts as position zero
    assign k         = last_day ? '0 : ycycle;
    assign leap_num  = LEAP_W'(k) * LEAP_W'(LEAP_MUL) + LEAP_W'(LEAP_ADD);
    assign year_next = YB'(year_q) * YB'(CYCLE_YEARS) + YB'(ycycle) - YB'(YEAR_BIAS);
    // day of year is small: carried modulo 2^YDAY_W
    assign yd0_next  = YDAY_W'(year_rem) + YDAY_W'(1) + YDAY_W'(DAYS_YEAR)
                     - YDAY_W'(k) * YDAY_W'(DAYS_YEAR);

    // leap_num >> 8 then / 11
    assign hmul = HMW'(hn8_reg) * HMW'(DIV11_MUL);
    // no year zero
    assign yadj = (year8_reg[YB-1] || (year8_reg == '0)) ? year8_reg - YB'(1) : year8_reg;

    assign yday_next = sp9_reg ? YDAY_W'(LONG_YEAR)
                               : yd0_9_reg - YDAY_W'(h9_reg) + YDAY_W'(H_BIAS);

    always_comb
    begin
        for (int i = 1; i < NMONTH; i++)
        begin
            ge[i-1] = yday10_reg >= YDAY_W'(month_start(MONTH_W'(i)));
        end
    end

    assign mi       = MONTH_W'($countones(ge));
    assign day_full = yday10_reg - YDAY_W'(month_start(mi)) + YDAY_W'(1);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            hn8_reg   <= leap_num[LEAP_SHIFT +: HN_W];
            year8_reg <= year_next;
            yd0_8_reg <= yd0_next;
            sp8_reg   <= last_day;
        end
        if (ld[1])
        begin
            h9_reg    <= hmul[DIV11_POST +: H_W];
            year9_reg <= yadj[YEAR_W-1:0];
            yd0_9_reg <= yd0_8_reg;
            sp9_reg   <= sp8_reg;
        end
        if (ld[2])
        begin
            yday10_reg <= yday_next;
            year10_reg <= year9_reg;
        end
        if (ld[3])
        begin
            year_reg  <= year10_reg;
            month_reg <= mi + MONTH_W'(1);
            day_reg   <= day_full[DAY_W-1:0];
        end
    end

    assign jalali_year  = year_reg;
    assign jalali_month = month_reg;
    assign jalali_day   = day_reg;

endmodule

// ===== rtl/julian_day_to_jalali_date.sv =====
// Julian day number to Jalali date converter, 2820-year arithmetic cycle.
// Takes one day number per request and returns the Jalali year, month and day.
// Twelve-stage pipeline: one request per clock sustained while the master side
// takes results; each request passes through every stage register before its
// result shows on the master side. Each stage holds a short run of constant
// arithmetic; each stage has its own valid bit, so empty stages keep taking
// requests while a result waits on the master side.
// Depends on jdj_pkg, jdj_cycle_div, jdj_year_cycle, jdj_date_split and the
// assertion macros header.
`include "julian_day_to_jalali_date_defines.svh"

module julian_day_to_jalali_date
    import jdj_pkg::*;
#(
    parameter int DAY_NUMBER_BITS = DAY_NUMBER_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((DAY_NUMBER_BITS + 7) / 8) * 8-1:0] s_tdata,   // day_number
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [OUT_TDATA_W-1:0]                    m_tdata
    // m_tdata: jalali_year, jalali_month, jalali_day
);

    localparam int QBITS      = DAY_NUMBER_BITS - CYCLE_Q_DROP;

    logic [NSTAGE-1:0]   vld_reg;
    logic [NSTAGE-1:0]   vld_next;
    logic [NSTAGE-1:0]   rdy;
    logic [NSTAGE-1:0]   ld;
    logic [NSTAGE-1:0]   upstream;

    logic [QBITS-1:0]    cycle_q;
    logic [REM_W-1:0]    cycle_rem;
    logic [QBITS-1:0]    year_q;
    logic [REM_W-1:0]    year_rem;
    logic [YCYCLE_W-1:0] ycycle;
    logic                last_day;
    logic [YEAR_W-1:0]   jalali_year;
    logic [MONTH_W-1:0]  jalali_month;
    logic [DAY_W-1:0]    jalali_day;

    // a stage can load when some stage at or after it is empty, or the sink takes
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_ctl
        assign rdy[i] = m_tready || !(&vld_reg[NSTAGE-1:i]);
    end

    assign upstream = {vld_reg[NSTAGE-2:0], s_tvalid};
    assign ld       = upstream & rdy;

    always_comb
    begin
        for (int i = 0; i < NSTAGE; i++)
        begin
            vld_next[i] = rdy[i] ? upstream[i] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    jdj_cycle_div #(
        .DAY_NUMBER_BITS (DAY_NUMBER_BITS),
        .QBITS           (QBITS)
    ) u_cycle_div (
        .clk        (clk),
        .ld         (ld[3:0]),
        .day_number (s_tdata[DAY_NUMBER_BITS-1:0]),
        .cycle_q    (cycle_q),
        .cycle_rem  (cycle_rem)
    );

    jdj_year_cycle #(
        .QBITS (QBITS)
    ) u_year_cycle (
        .clk       (clk),
        .ld        (ld[7:4]),
        .cycle_q   (cycle_q),
        .cycle_rem (cycle_rem),
        .year_q    (year_q),
        .year_rem  (year_rem),
        .ycycle    (ycycle),
        .last_day  (last_day)
    );

    jdj_date_split #(
        .QBITS (QBITS)
    ) u_date_split (
        .clk          (clk),
        .ld           (ld[11:8]),
        .year_q       (year_q),
        .year_rem     (year_rem),
        .ycycle       (ycycle),
        .last_day     (last_day),
        .jalali_year  (jalali_year),
        .jalali_month (jalali_month),
        .jalali_day   (jalali_day)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = {{(OUT_TDATA_W - YEAR_W - MONTH_W - DAY_W){1'b0}},
                       jalali_day, jalali_month, jalali_year};

    `JDJ_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0],
        "accepted request did not enter the pipeline")
    `JDJ_ASSERT_NOW(a_full_stall, (&vld_reg) && !m_tready, !s_tready,
        "request accepted into a full stalled pipeline")
    `JDJ_ASSERT_NOW(a_month_range, m_tvalid,
        (jalali_month != '0) && (jalali_month <= MONTH_W'(NMONTH)),
        "month out of range")
    `JDJ_ASSERT_NOW(a_day_nonzero, m_tvalid, jalali_day != '0,
        "day of month is zero")
    `JDJ_ASSERT_NOW(a_short_month, m_tvalid && (jalali_month >= MONTH_W'(7)),
        jalali_day <= DAY_W'(30),
        "day beyond the end of a 30-day month")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for julian_day_to_jalali_date: clocked driver and monitor
// compare every result with a built-in date predictor.
// Depends on jdj_pkg and the julian_day_to_jalali_date RTL.
`timescale 1ns / 1ps

module tb_top;
    import jdj_pkg::*;

    localparam int  DAY_BITS     = 23;
    localparam int  IN_W         = 24;
    localparam int  N_RANDOM     = 1100;
    localparam int  PIPE_DEPTH   = NSTAGE;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  HOLD_AT      = 150;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DAY_MAX      = (1 << DAY_BITS) - 1;

    localparam longint EPOCH_JDN     = 2121445;
    localparam longint PERIOD_DAYS   = 1029983;
    localparam longint PRE_YEAR1_JDN = 1948319;
    localparam longint PERIOD_YEARS  = 2820;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } phase_t;

    typedef struct packed {
        logic [DAY_W-1:0]          day;
        logic [MONTH_W-1:0]        month;
        logic signed [YEAR_W-1:0]  year;
    } jdate_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata;   // day_number
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // jalali_year, jalali_month, jalali_day

    logic [DAY_BITS-1:0] day_queue[$];
    jdate_t              date_queue[$];
    int                  n_total;
    int                  n_issued;
    int                  n_errors;
    int                  n_cycles;
    int                  hold_left;
    logic                hold_done;
    phase_t              phase;
    jdate_t              got;

    julian_day_to_jalali_date DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint floor_mod(input longint a, input longint b);
        longint r;
        r = a % b;
        if (r < 0)
        begin
            r = r + b;
        end
        return r;
    endfunction

    // day number on which the given date falls
    function automatic longint date_to_jdn(input longint y, input longint m, input longint d);
        longint base;
        longint cy;
        longint mdays;
        base  = y - ((y >= 0) ? 474 : 473);
        cy    = 474 + floor_mod(base, PERIOD_YEARS);
        mdays = (m <= 7) ? (m - 1) * 31 : (m - 1) * 30 + 6;
        return d + mdays + floor_div(cy * 682 - 110, 2816) + (cy - 1) * 365
            + floor_div(base, PERIOD_YEARS) * PERIOD_DAYS + PRE_YEAR1_JDN;
    endfunction

    function automatic jdate_t jdn_to_date(input logic [DAY_BITS-1:0] jdn);
        longint d;
        longint offset;
        longint cyc;
        longint rem;
        longint ycyc;
        longint a1;
        longint a2;
        longint y;
        longint yday;
        longint m;
        jdate_t r;
        d      = longint'(jdn);
        offset = d - EPOCH_JDN;
        cyc    = floor_div(offset, PERIOD_DAYS);
        rem    = floor_mod(offset, PERIOD_DAYS);
        if (rem == PERIOD_DAYS - 1)
        begin
            ycyc = PERIOD_YEARS;
        end
        else
        begin
            a1   = rem / 366;
            a2   = rem % 366;
            ycyc = (2134 * a1 + 2816 * a2 + 2815) / 1028522 + a1 + 1;
        end
        y = ycyc + PERIOD_YEARS * cyc + 474;
        if (y <= 0)
        begin
            y = y - 1;
        end
        yday = d - date_to_jdn(y, 1, 1) + 1;
        if (yday <= 186)
        begin
            m = floor_div(yday + 30, 31);
        end
        else
        begin
            m = floor_div(yday + 23, 30);
        end
        r.year  = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d - date_to_jdn(y, m, 1) + 1);
        return r;
    endfunction

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $time, what);
        n_errors++;
    endtask

    function automatic logic [DAY_BITS-1:0] pick_day();
        longint v;
        longint y;
        int     mode;
        mode = $urandom_range(9);
        if (mode < 5)
        begin
            v = $urandom_range(DAY_MAX);
        end
        else if (mode < 7)
        begin
            // near the last day of a cycle
            v = EPOCH_JDN - 1 + (longint'($urandom_range(8)) - 2) * PERIOD_DAYS
                + longint'($urandom_range(8)) - 4;
        end
        else
        begin
            // near a year or month start, negative years included
            y = longint'($urandom_range(21999)) - 5000;
            if (y == 0)
            begin
                y = 1;
            end
            v = date_to_jdn(y, $urandom_range(1, 12), 1) + longint'($urandom_range(2)) - 1;
        end
        if (v < 0 || v > DAY_MAX)
        begin
            v = $urandom_range(DAY_MAX);
        end
        return DAY_BITS'(v);
    endfunction

    always_comb
    begin
        if (n_issued * 4 < n_total)
            phase = PH_STEADY;
        else if (n_issued * 2 < n_total)
            phase = PH_SRC_IDLE;
        else if (n_issued * 4 < n_total * 3)
            phase = PH_SINK_STALL;
        else
            phase = PH_BOTH;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            n_issued <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                date_queue.push_back(jdn_to_date(s_tdata[DAY_BITS-1:0]));
            end
            if (day_queue.size() > 0 &&
                !((phase == PH_SRC_IDLE && $urandom_range(99) < 52) ||
                  (phase == PH_BOTH && $urandom_range(99) < 16)))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_W'(day_queue.pop_front());
                n_issued <= n_issued + 1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long sink hold-off so the pipeline backs up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_issued >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
            m_tready <= 1'b0;
        else if (phase == PH_SINK_STALL)
            m_tready <= ($urandom_range(99) >= 52);
        else if (phase == PH_BOTH)
            m_tready <= ($urandom_range(99) >= 16);
        else
            m_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = jdate_t'(m_tdata[YEAR_W+MONTH_W+DAY_W-1:0]);
            if (date_queue.size() == 0)
            begin
                report($sformatf("unexpected result %h", m_tdata));
            end
            else
            begin
                if (got.year !== date_queue[0].year)
                    report($sformatf("year %0d, want %0d", got.year, date_queue[0].year));
                if (got.month !== date_queue[0].month)
                    report($sformatf("month %0d, want %0d", got.month, date_queue[0].month));
                if (got.day !== date_queue[0].day)
                    report($sformatf("day %0d, want %0d", got.day, date_queue[0].day));
                void'(date_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        n_errors = 0;
        rst_n    = 1'b0;
        // cycle ends, year -1 / year 1 boundary, month 6/7 switch, range ends
        day_queue.push_back(DAY_BITS'(0));
        day_queue.push_back(DAY_BITS'(1));
        day_queue.push_back(DAY_BITS'(DAY_MAX));
        day_queue.push_back(DAY_BITS'(DAY_MAX - 1));
        day_queue.push_back(DAY_BITS'(1 << (DAY_BITS - 1)));
        day_queue.push_back(DAY_BITS'((1 << (DAY_BITS - 1)) - 1));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN - 1));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN + PERIOD_DAYS - 1));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN + PERIOD_DAYS - 2));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN + PERIOD_DAYS));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN - PERIOD_DAYS - 1));
        day_queue.push_back(DAY_BITS'(EPOCH_JDN + 5 * PERIOD_DAYS - 1));
        day_queue.push_back(DAY_BITS'(PRE_YEAR1_JDN));
        day_queue.push_back(DAY_BITS'(PRE_YEAR1_JDN + 1));
        day_queue.push_back(DAY_BITS'(date_to_jdn(-1, 1, 1)));
        day_queue.push_back(DAY_BITS'(date_to_jdn(-2, 12, 1) - 1));
        day_queue.push_back(DAY_BITS'(date_to_jdn(1400, 7, 1) - 1));
        day_queue.push_back(DAY_BITS'(date_to_jdn(1400, 7, 1)));
        day_queue.push_back(DAY_BITS'(date_to_jdn(1403, 1, 1) - 1));
        day_queue.push_back(DAY_BITS'(date_to_jdn(1403, 12, 30)));
        day_queue.push_back(DAY_BITS'(date_to_jdn(-5000, 1, 1)));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            day_queue.push_back(pick_day());
        end
        n_total = day_queue.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (day_queue.size() > 0 || s_tvalid || date_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (n_errors == 0 && date_queue.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
